// ----- design/pee_pkg.sv -----
package pee_pkg;

    localparam int DATA_W          = 32;
    localparam int SYM_W           = 8;
    localparam int STATUS_W        = 3;
    localparam int CFG_IDX_W       = 2;
    localparam int STACK_DEPTH_DEF = 32;

    typedef logic [DATA_W-1:0]   word_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [SYM_W-1:0]    sym_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_OVERFLOW  = 3'd1;
    localparam status_t ST_UNDERFLOW = 3'd2;
    localparam status_t ST_DIVZERO   = 3'd3;
    localparam status_t ST_BADSYM    = 3'd4;

    localparam cfg_idx_t CFG_VALUE_A = 2'd0;
    localparam cfg_idx_t CFG_VALUE_B = 2'd1;
    localparam cfg_idx_t CFG_VALUE_C = 2'd2;
    localparam cfg_idx_t CFG_VALUE_D = 2'd3;

    localparam sym_t SYM_PLUS  = 8'h2B;
    localparam sym_t SYM_MINUS = 8'h2D;
    localparam sym_t SYM_STAR  = 8'h2A;
    localparam sym_t SYM_SLASH = 8'h2F;
    localparam sym_t SYM_A     = 8'h61;
    localparam sym_t SYM_D     = 8'h64;
    localparam sym_t SYM_E     = 8'h65;
    localparam sym_t SYM_Z     = 8'h7A;
    localparam sym_t SYM_UA    = 8'h41;
    localparam sym_t SYM_UZ    = 8'h5A;

    function automatic word_t magnitude(input word_t v);
        magnitude = v[DATA_W-1] ? (word_t'(0) - v) : v;
    endfunction

endpackage

// ----- design/pee_ram.sv -----
module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/pee_div.sv -----
module pee_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  pee_pkg::word_t dividend,
    input  pee_pkg::word_t divisor,
    output logic          done,
    output pee_pkg::word_t quotient
);

    localparam int W     = pee_pkg::DATA_W;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     den_reg;
    logic             neg_reg;

    logic [W:0]       shifted;
    logic [W+1:0]     diff;
    logic             fits;

    // One quotient bit per cycle, restoring division on magnitudes.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[W-1]};
        diff    = {1'b0, shifted} - {2'b00, den_reg};
        fits    = !diff[W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= pee_pkg::magnitude(dividend);
            den_reg <= pee_pkg::magnitude(divisor);
            neg_reg <= dividend[W-1] ^ divisor[W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

endmodule

// ----- design/postfix_expression_evaluator_unit.sv -----
// Postfix evaluator: takes one expression character per transaction. Letters a-d push the
// value programmed in value_a..value_d, + - * / combine the two top operands, and the
// transaction flagged end_of_expression returns the top of stack (0 when empty) with the
// first error seen in that expression, then empties the stack. One character is in work
// at a time. A push, an ignored letter, a bad symbol or an operator with fewer than two
// operands is done in the idle state; + - * go through read of the second operand from
// the stack RAM, compute and write back, and / waits on the one-bit-per-cycle divider
// before write back unless the divisor is zero. A final character then loads the result
// register, held off while result_stall holds the previous one. The top of stack is kept
// in a register, so an operator reads the RAM only once.
module postfix_expression_evaluator_unit #(
    parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [pee_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pee_pkg::DATA_W-1:0]          cfg_data,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [pee_pkg::SYM_W-1:0]           symbol,
    input  logic                                end_of_expression,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [pee_pkg::DATA_W-1:0]   value,
    output logic [pee_pkg::STATUS_W-1:0]        status
);

    localparam int W  = pee_pkg::DATA_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPER,
        S_DIV,
        S_WB,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    pee_pkg::status_t err_reg, err_next;
    logic            result_valid_reg, result_valid_next;
    pee_pkg::word_t  value_reg, value_next;
    pee_pkg::status_t status_reg, status_next;

    pee_pkg::word_t  cfg_reg [4];

    pee_pkg::word_t  top_reg, top_next;
    pee_pkg::word_t  res_reg, res_next;
    op_t             op_reg, op_next;
    logic            last_reg, last_next;

    logic            accept;
    logic            emit_go;
    logic [CW-1:0]   count_m2;
    pee_pkg::sym_t   sym_off;
    pee_pkg::word_t  push_val;
    logic [2*W-1:0]  product;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    pee_pkg::word_t  ram_wdata;
    pee_pkg::word_t  ram_rdata;

    logic            div_start;
    logic            div_done;
    pee_pkg::word_t  div_quot;

    assign accept   = item_valid && !item_stall;
    assign emit_go  = (state_reg == S_EMIT) && (!result_valid_reg || !result_stall);
    assign count_m2 = count_reg - CW'(2);
    assign sym_off  = symbol - pee_pkg::SYM_A;
    assign push_val = cfg_reg[sym_off[1:0]];
    assign product  = ram_rdata * top_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pee_pkg::CFG_VALUE_A: cfg_reg[0] <= cfg_data;
                pee_pkg::CFG_VALUE_B: cfg_reg[1] <= cfg_data;
                pee_pkg::CFG_VALUE_C: cfg_reg[2] <= cfg_data;
                pee_pkg::CFG_VALUE_D: cfg_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        err_next          = err_reg;
        result_valid_next = result_valid_reg;
        value_next        = value_reg;
        status_next       = status_reg;
        top_next          = top_reg;
        res_next          = res_reg;
        op_next           = op_reg;
        last_next         = last_reg;
        ram_we            = 1'b0;
        ram_waddr         = count_reg[AW-1:0];
        ram_wdata         = push_val;
        div_start         = 1'b0;

        // Drop the result once taken; a new one may load in the same cycle.
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next  = end_of_expression;
                    state_next = end_of_expression ? S_EMIT : S_IDLE;
                    if (symbol >= pee_pkg::SYM_A && symbol <= pee_pkg::SYM_D)
                    begin
                        if (count_reg < CW'(STACK_DEPTH))
                        begin
                            ram_we     = 1'b1;
                            top_next   = push_val;
                            count_next = count_reg + 1'b1;
                        end
                        else if (err_reg == pee_pkg::ST_OK)
                        begin
                            err_next = pee_pkg::ST_OVERFLOW;
                        end
                    end
                    else if ((symbol >= pee_pkg::SYM_UA && symbol <= pee_pkg::SYM_UZ) ||
                             (symbol >= pee_pkg::SYM_E && symbol <= pee_pkg::SYM_Z))
                    begin
                        // ignored letter
                    end
                    else if (symbol == pee_pkg::SYM_PLUS || symbol == pee_pkg::SYM_MINUS ||
                             symbol == pee_pkg::SYM_STAR || symbol == pee_pkg::SYM_SLASH)
                    begin
                        if (count_reg < CW'(2))
                        begin
                            if (err_reg == pee_pkg::ST_OK)
                            begin
                                err_next = pee_pkg::ST_UNDERFLOW;
                            end
                        end
                        else
                        begin
                            // Second operand is read now; the first is top_reg.
                            state_next = S_OPER;
                            case (symbol)
                                pee_pkg::SYM_PLUS:  op_next = OP_ADD;
                                pee_pkg::SYM_MINUS: op_next = OP_SUB;
                                pee_pkg::SYM_STAR:  op_next = OP_MUL;
                                default:            op_next = OP_DIV;
                            endcase
                        end
                    end
                    else if (err_reg == pee_pkg::ST_OK)
                    begin
                        err_next = pee_pkg::ST_BADSYM;
                    end
                end
            end

            S_OPER:
            begin
                state_next = S_WB;
                case (op_reg)
                    OP_ADD: res_next = ram_rdata + top_reg;
                    OP_SUB: res_next = ram_rdata - top_reg;
                    OP_MUL: res_next = product[W-1:0];
                    default:
                    begin
                        if (top_reg == '0)
                        begin
                            res_next = '0;
                            if (err_reg == pee_pkg::ST_OK)
                            begin
                                err_next = pee_pkg::ST_DIVZERO;
                            end
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                endcase
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_quot;
                    state_next = S_WB;
                end
            end

            S_WB:
            begin
                // Pop two, push one: the result lands where the second operand was.
                ram_we     = 1'b1;
                ram_waddr  = count_m2[AW-1:0];
                ram_wdata  = res_reg;
                top_next   = res_reg;
                count_next = count_reg - 1'b1;
                state_next = last_reg ? S_EMIT : S_IDLE;
            end

            S_EMIT:
            begin
                if (emit_go)
                begin
                    result_valid_next = 1'b1;
                    value_next        = (count_reg != '0) ? top_reg : '0;
                    status_next       = err_reg;
                    count_next        = '0;
                    err_next          = pee_pkg::ST_OK;
                    state_next        = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            err_reg          <= pee_pkg::ST_OK;
            result_valid_reg <= 1'b0;
            value_reg        <= '0;
            status_reg       <= pee_pkg::ST_OK;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            err_reg          <= err_next;
            result_valid_reg <= result_valid_next;
            value_reg        <= value_next;
            status_reg       <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        res_reg  <= res_next;
        op_reg   <= op_next;
        last_reg <= last_next;
    end

    // Only the read made on accepting an operator is used; that is never a write cycle, and it
    // never targets the entry written by the previous push, so no bypass is needed.
    pee_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (count_m2[AW-1:0]),
        .rdata (ram_rdata)
    );

    pee_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ram_rdata),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign value        = value_reg;
    assign status       = status_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg) == S_EMIT)
        else $error("result raised outside emit");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> (count_reg == '0) && (err_reg == pee_pkg::ST_OK))
        else $error("stack not emptied after result");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide wait");
`endif

endmodule

// ----- verif/tb_top.sv -----
module tb_top;

    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  SETTLE_CYCLES = 60;
    localparam int  RANDOM_ITEMS = 500;

    localparam pee_pkg::sym_t SYM_B    = pee_pkg::SYM_A + 8'd1;
    localparam pee_pkg::sym_t SYM_NUL  = 8'h00;
    localparam pee_pkg::sym_t SYM_HASH = 8'h23;

    typedef struct {
        pee_pkg::word_t   value;
        pee_pkg::status_t status;
    } result_t;

    logic              clk;
    logic              rst_n             = 1'b0;
    logic              cfg_write         = 1'b0;
    pee_pkg::cfg_idx_t cfg_index         = pee_pkg::CFG_VALUE_A;
    pee_pkg::word_t    cfg_data          = '0;
    logic              item_valid        = 1'b0;
    logic              item_stall;
    pee_pkg::sym_t     symbol            = '0;
    logic              end_of_expression = 1'b0;
    logic              result_valid;
    logic              result_stall      = 1'b0;
    logic signed [pee_pkg::DATA_W-1:0] value;
    pee_pkg::status_t  status;

    // evaluator shadow state
    pee_pkg::word_t    letter_value [4];
    pee_pkg::word_t    shadow_stack [pee_pkg::STACK_DEPTH_DEF];
    int                shadow_depth;
    pee_pkg::status_t  shadow_status;

    result_t    pending_results [$];
    result_t    oldest;
    int         fail_count = 0;
    int         cycle_count = 0;
    int         counted_items;
    bit         gaps_enabled;

    postfix_expression_evaluator_unit u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .symbol            (symbol),
        .end_of_expression (end_of_expression),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .value             (value),
        .status            (status)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[postfix_expression_evaluator_unit] ERROR");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        result_stall <= gaps_enabled && ($urandom_range(0, 99) < 20);
    end

    // ---------------------------------------------------------------- prediction

    function automatic bit is_ignored_letter(input pee_pkg::sym_t s);
        return (s >= pee_pkg::SYM_UA && s <= pee_pkg::SYM_UZ) ||
               (s >= pee_pkg::SYM_E && s <= pee_pkg::SYM_Z);
    endfunction

    function automatic void raise_status(input pee_pkg::status_t code);
        if (shadow_status == pee_pkg::ST_OK)
            shadow_status = code;
    endfunction

    function automatic void push_operand(input pee_pkg::word_t v);
        if (shadow_depth >= pee_pkg::STACK_DEPTH_DEF)
            raise_status(pee_pkg::ST_OVERFLOW);
        else
        begin
            shadow_stack[shadow_depth] = v;
            shadow_depth++;
        end
    endfunction

    function automatic pee_pkg::word_t quotient_toward_zero(input pee_pkg::word_t num,
                                                            input pee_pkg::word_t den);
        pee_pkg::word_t abs_num;
        pee_pkg::word_t abs_den;
        pee_pkg::word_t q;
        abs_num = num[pee_pkg::DATA_W-1] ? -num : num;
        abs_den = den[pee_pkg::DATA_W-1] ? -den : den;
        q = abs_num / abs_den;
        return (num[pee_pkg::DATA_W-1] ^ den[pee_pkg::DATA_W-1]) ? -q : q;
    endfunction

    function automatic void combine_top(input pee_pkg::sym_t op);
        pee_pkg::word_t rhs;
        pee_pkg::word_t lhs;
        pee_pkg::word_t res;
        if (shadow_depth < 2)
        begin
            raise_status(pee_pkg::ST_UNDERFLOW);
            return;
        end
        rhs = shadow_stack[shadow_depth-1];
        lhs = shadow_stack[shadow_depth-2];
        shadow_depth -= 2;
        case (op)
            pee_pkg::SYM_PLUS:  res = lhs + rhs;
            pee_pkg::SYM_MINUS: res = lhs - rhs;
            pee_pkg::SYM_STAR:  res = lhs * rhs;
            default:
            begin
                if (rhs == '0)
                begin
                    raise_status(pee_pkg::ST_DIVZERO);
                    res = '0;
                end
                else
                    res = quotient_toward_zero(lhs, rhs);
            end
        endcase
        push_operand(res);
    endfunction

    function automatic void evaluate_symbol(input pee_pkg::sym_t s, input logic last);
        pee_pkg::sym_t offset;
        result_t       r;
        offset = s - pee_pkg::SYM_A;
        if (s >= pee_pkg::SYM_A && s <= pee_pkg::SYM_D)
            push_operand(letter_value[offset[1:0]]);
        else if (is_ignored_letter(s))
            ;
        else if (s == pee_pkg::SYM_PLUS || s == pee_pkg::SYM_MINUS ||
                 s == pee_pkg::SYM_STAR || s == pee_pkg::SYM_SLASH)
            combine_top(s);
        else
            raise_status(pee_pkg::ST_BADSYM);
        if (last)
        begin
            r.value  = (shadow_depth > 0) ? shadow_stack[shadow_depth-1] : '0;
            r.status = shadow_status;
            pending_results.push_back(r);
            shadow_depth  = 0;
            shadow_status = pee_pkg::ST_OK;
        end
    endfunction

    // ---------------------------------------------------------------- checking

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none pending: value=%0d status=%0d",
                         $time, value, status);
                fail_count++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (value !== oldest.value)
                begin
                    $display("%0t: value mismatch: expected %0d actual %0d",
                             $time, $signed(oldest.value), value);
                    fail_count++;
                end
                if (status !== oldest.status)
                begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, oldest.status, status);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_symbol(input pee_pkg::sym_t s, input logic last);
        @(negedge clk);
        while (gaps_enabled && $urandom_range(0, 99) < 20)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid        <= 1'b1;
        symbol            <= s;
        end_of_expression <= last;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        evaluate_symbol(s, last);
        if (!is_ignored_letter(s))
            counted_items++;
    endtask

    task automatic send_expr(input string text);
        for (int i = 0; i < text.len(); i++)
            send_symbol(pee_pkg::sym_t'(text[i]), i == text.len() - 1);
    endtask

    // hold off until every pending result is out and the block has gone quiet
    task automatic wait_for_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input pee_pkg::cfg_idx_t idx, input pee_pkg::word_t data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        letter_value[idx] = data;
    endtask

    task automatic write_all_regs(input pee_pkg::word_t va, input pee_pkg::word_t vb,
                                  input pee_pkg::word_t vc, input pee_pkg::word_t vd);
        wait_for_results();
        write_reg(pee_pkg::CFG_VALUE_A, va);
        write_reg(pee_pkg::CFG_VALUE_B, vb);
        write_reg(pee_pkg::CFG_VALUE_C, vc);
        write_reg(pee_pkg::CFG_VALUE_D, vd);
    endtask

    function automatic pee_pkg::word_t pick_reg_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return pee_pkg::word_t'($urandom_range(0, 18)) - 32'd9;
            default: return $urandom;
        endcase
    endfunction

    function automatic pee_pkg::sym_t pick_operator();
        case ($urandom_range(0, 3))
            0:       return pee_pkg::SYM_PLUS;
            1:       return pee_pkg::SYM_MINUS;
            2:       return pee_pkg::SYM_STAR;
            default: return pee_pkg::SYM_SLASH;
        endcase
    endfunction

    function automatic pee_pkg::sym_t pick_ignored_letter();
        if ($urandom_range(0, 1))
            return pee_pkg::SYM_UA + pee_pkg::sym_t'($urandom_range(0, 25));
        return pee_pkg::SYM_E + pee_pkg::sym_t'($urandom_range(0, 21));
    endfunction

    task automatic send_wellformed(input int operands);
        int            depth;
        int            left;
        pee_pkg::sym_t s;
        depth = 0;
        left  = operands;
        while (left > 0 || depth > 1)
        begin
            if (left > 0 && (depth < 2 || $urandom_range(0, 1)))
            begin
                s = pee_pkg::SYM_A + pee_pkg::sym_t'($urandom_range(0, 3));
                left--;
                depth++;
            end
            else
            begin
                s = pick_operator();
                depth--;
            end
            if ($urandom_range(0, 15) == 0)
                send_symbol(pick_ignored_letter(), 1'b0);
            send_symbol(s, left == 0 && depth <= 1);
        end
    endtask

    task automatic send_noise(input int length);
        pee_pkg::sym_t s;
        for (int i = 0; i < length; i++)
        begin
            case ($urandom_range(0, 3))
                0:       s = pee_pkg::SYM_A + pee_pkg::sym_t'($urandom_range(0, 3));
                1:       s = pick_operator();
                default: s = pee_pkg::sym_t'($urandom_range(0, 255));
            endcase
            send_symbol(s, i == length - 1);
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_power_on_defaults();
        send_expr("a");
        send_expr("+");
        send_expr("e");
    endtask

    task automatic test_arithmetic();
        write_all_regs(32'd7, 32'hFFFF_FFFD, 32'h8000_0000, 32'hFFFF_FFFF);
        send_expr("ab+");
        send_expr("ab-");
        send_expr("ab*");
        send_expr("ab/");
        send_expr("cd/");
        send_expr("cd*");
        send_expr("aaa-/");
        write_all_regs(32'h7FFF_FFFF, 32'd1, 32'd0, 32'h8000_0000);
        send_expr("ab+");
        send_expr("dc/");
    endtask

    task automatic test_special_cases();
        // bad symbol, NUL included, leaves the stack alone
        send_symbol(pee_pkg::SYM_A, 1'b0);
        send_symbol(SYM_NUL, 1'b0);
        send_symbol(SYM_B, 1'b0);
        send_symbol(pee_pkg::SYM_PLUS, 1'b1);
        // first error sticks
        send_expr("+#Z");
        send_expr("a-");
        send_symbol(SYM_HASH, 1'b1);
    endtask

    task automatic test_stack_full();
        send_expr("abcdabcdabcdabcdabcdabcdabcdabcda");
        send_expr("b");
    endtask

    task automatic test_random();
        int target;
        int n_expr;
        target = counted_items + RANDOM_ITEMS;
        n_expr = 0;
        while (counted_items < target)
        begin
            if (n_expr % 30 == 0)
                write_all_regs(pick_reg_value(), pick_reg_value(), pick_reg_value(),
                               pick_reg_value());
            gaps_enabled = !(counted_items >= target - 300 && counted_items < target - 150);
            if ($urandom_range(0, 99) < 75)
                send_wellformed($urandom_range(0, 19) == 0 ? $urandom_range(30, 36)
                                                           : $urandom_range(1, 6));
            else
                send_noise($urandom_range(1, 6));
            n_expr++;
        end
        gaps_enabled = 1'b1;
    endtask

    initial
    begin
        for (int i = 0; i < 4; i++)
            letter_value[i] = '0;
        shadow_depth  = 0;
        shadow_status = pee_pkg::ST_OK;
        counted_items = 0;
        gaps_enabled  = 1'b1;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_power_on_defaults();
        test_arithmetic();
        test_special_cases();
        test_stack_full();
        test_random();
        wait_for_results();

        if (fail_count == 0)
            $display("[postfix_expression_evaluator_unit] OK");
        else
            $display("[postfix_expression_evaluator_unit] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
design/pee_pkg.sv
design/pee_ram.sv
design/pee_div.sv
design/postfix_expression_evaluator_unit.sv
verif/tb_top.sv
